// ===== design/bcd_pkg.sv =====
package bcd_pkg;

    localparam int WORD_W = 32;
    localparam int ACTION_W = 3;
    localparam int CAP_W = 5;
    localparam int FILL_W = 5;

    // reset capacity before limiting to the built depth
    localparam int CAP_RESET_VALUE = 16;

    localparam logic [ACTION_W-1:0] ACT_QUERY      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PUSH_REAR  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_POP_REAR   = 3'd4;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [WORD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] front_word;
        logic signed [WORD_W-1:0] rear_word;
        logic                     empty_flag;
        logic                     full_flag;
        logic [FILL_W-1:0]        fill_count;
    } result_t;

    // one operation broadcast to every cell of the row
    typedef struct packed {
        logic clear;
        logic shift_right;
        logic shift_left;
        logic push_rear;
        logic pop_rear;
    } cell_ctrl_t;

endpackage

// ===== design/bcd_cell.sv =====
module bcd_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bcd_pkg::cell_ctrl_t           ctrl,
    input  logic [bcd_pkg::WORD_W-1:0]    push_word,
    input  logic [bcd_pkg::WORD_W-1:0]    left_word,
    input  logic                          left_valid,
    input  logic [bcd_pkg::WORD_W-1:0]    right_word,
    input  logic                          right_valid,
    output logic [bcd_pkg::WORD_W-1:0]    word,
    output logic                          valid,
    output logic                          is_rear
);

    logic [bcd_pkg::WORD_W-1:0] word_reg;
    logic [bcd_pkg::WORD_W-1:0] word_next;
    logic                       valid_reg;
    logic                       valid_next;

    always_comb
    begin
        word_next  = word_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift_right)
        begin
            word_next  = left_word;
            valid_next = left_valid;
        end
        else if (ctrl.shift_left)
        begin
            word_next  = right_word;
            valid_next = right_valid;
        end
        else if (ctrl.push_rear)
        begin
            // first free cell takes the word
            if (!valid_reg && left_valid)
            begin
                word_next  = push_word;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.pop_rear)
        begin
            if (valid_reg && !right_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign valid   = valid_reg;
    assign is_rear = valid_reg && !right_valid;

endmodule

// ===== design/bounded_circular_deque.sv =====
// channel   | handshake                     | payload
// ----------+-------------------------------+----------------------------------
// command   | start in, busy out            | cmd (action, value)
// result    | done out, one-cycle strobe    | result (ok, words, flags, count)
// config    | cfg_valid in, cfg_ready out   | cfg_data (capacity)
//
// for every item, the accepting edge updates the cell row, and
// the next cycle shows the result with done high while busy holds off start
// the result is read from the updated row, so it can only show after that
// edge; reset empties the deque and loads the default capacity
// results cannot be stalled: done is high for exactly one cycle per item
module bounded_circular_deque
#(
    parameter int DEPTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  bcd_pkg::cmd_t                 cmd,
    output logic                          busy,
    output logic                          done,
    output bcd_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcd_pkg::CAP_W-1:0]     cfg_data
);

    // count must hold the depth itself
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_RESET =
        (DEPTH < bcd_pkg::CAP_RESET_VALUE) ? DEPTH : bcd_pkg::CAP_RESET_VALUE;

    // sequencer states
    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REPORT = 1'b1;

    logic                        state_reg;
    logic                        state_next;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [CNT_W-1:0]            cap_reg;
    logic [CNT_W-1:0]            cap_next;
    logic                        ok_reg;
    logic                        ok_next;

    logic                        accept;
    logic                        cfg_write;
    logic                        is_full;
    logic                        is_empty;
    bcd_pkg::cell_ctrl_t         ctrl;

    logic [bcd_pkg::WORD_W-1:0]  cell_word [DEPTH];
    logic [DEPTH-1:0]            cell_valid;
    logic [DEPTH-1:0]            cell_rear;
    logic [bcd_pkg::WORD_W-1:0]  rear_sel;

    assign busy      = (state_reg == ST_REPORT);
    // a command offered at start goes first, the capacity write waits
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    assign is_full  = (count_reg >= cap_reg);
    assign is_empty = (count_reg == '0);

    // decode the operation; failed pushes and pops leave the row alone
    always_comb
    begin
        ctrl       = '0;
        ok_next    = ok_reg;
        count_next = count_reg;
        if (cfg_write)
        begin
            ctrl.clear = 1'b1;
            count_next = '0;
        end
        else if (accept)
        begin
            ok_next = 1'b0;
            case (cmd.action)
                bcd_pkg::ACT_QUERY:
                begin
                    ok_next = 1'b1;
                end
                bcd_pkg::ACT_PUSH_FRONT:
                begin
                    if (!is_full)
                    begin
                        ctrl.shift_right = 1'b1;
                        count_next       = count_reg + 1'b1;
                        ok_next          = 1'b1;
                    end
                end
                bcd_pkg::ACT_PUSH_REAR:
                begin
                    if (!is_full)
                    begin
                        ctrl.push_rear = 1'b1;
                        count_next     = count_reg + 1'b1;
                        ok_next        = 1'b1;
                    end
                end
                bcd_pkg::ACT_POP_FRONT:
                begin
                    if (!is_empty)
                    begin
                        ctrl.shift_left = 1'b1;
                        count_next      = count_reg - 1'b1;
                        ok_next         = 1'b1;
                    end
                end
                bcd_pkg::ACT_POP_REAR:
                begin
                    if (!is_empty)
                    begin
                        ctrl.pop_rear = 1'b1;
                        count_next    = count_reg - 1'b1;
                        ok_next       = 1'b1;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // capacity is held between one and the built depth
    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_write)
        begin
            if (cfg_data == '0)
            begin
                cap_next = CNT_W'(1);
            end
            else if (32'(cfg_data) > 32'(DEPTH))
            begin
                cap_next = CNT_W'(DEPTH);
            end
            else
            begin
                cap_next = CNT_W'(cfg_data);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cap_reg   <= CNT_W'(CAP_RESET);
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            ok_reg    <= ok_next;
        end
    end

    // row of cells: cell 0 holds the front, valid cells are packed from 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [bcd_pkg::WORD_W-1:0] left_word;
        logic                       left_valid;
        logic [bcd_pkg::WORD_W-1:0] right_word;
        logic                       right_valid;

        if (i == 0)
        begin : g_first
            // a front push enters here
            assign left_word  = cmd.value;
            assign left_valid = 1'b1;
        end
        else
        begin : g_inner_left
            assign left_word  = cell_word[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_word  = cmd.value;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner_right
            assign right_word  = cell_word[i+1];
            assign right_valid = cell_valid[i+1];
        end

        bcd_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .push_word   (cmd.value),
            .left_word   (left_word),
            .left_valid  (left_valid),
            .right_word  (right_word),
            .right_valid (right_valid),
            .word        (cell_word[i]),
            .valid       (cell_valid[i]),
            .is_rear     (cell_rear[i])
        );
    end

    // at most one cell flags itself as the rear
    always_comb
    begin
        rear_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_sel = rear_sel | (cell_word[i] & {bcd_pkg::WORD_W{cell_rear[i]}});
        end
    end

    // result shown from the updated row during the report cycle
    assign done = (state_reg == ST_REPORT);

    always_comb
    begin
        result.ok         = ok_reg;
        result.empty_flag = is_empty;
        result.full_flag  = is_full;
        result.fill_count = bcd_pkg::FILL_W'(count_reg);
        if (is_empty)
        begin
            result.front_word = bcd_pkg::EMPTY_WORD;
            result.rear_word  = bcd_pkg::EMPTY_WORD;
        end
        else
        begin
            result.front_word = cell_word[0];
            result.rear_word  = rear_sel;
        end
    end

endmodule

// ===== verif/deque_checker.sv =====
`timescale 1ns / 100ps

module deque_checker
#(
    parameter int DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  bcd_pkg::cmd_t             cmd,
    input  logic                      busy,
    input  logic                      done,
    input  bcd_pkg::result_t          result,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [bcd_pkg::CAP_W-1:0] cfg_data,
    output int                        fail_count,
    output int                        pending_count
);

    import bcd_pkg::*;

    // shadow copy of the deque
    logic signed [WORD_W-1:0] ring [DEPTH];
    logic [3:0]               head_ptr;
    logic [3:0]               tail_ptr;
    logic [FILL_W-1:0]        occupancy;
    logic [CAP_W-1:0]         held_cap;

    result_t expected_results [$];

    function automatic logic [CAP_W-1:0] clamp_capacity(logic [CAP_W-1:0] v);
        if (v == 0)
        begin
            return CAP_W'(1);
        end
        if (v > DEPTH)
        begin
            return CAP_W'(DEPTH);
        end
        return v;
    endfunction

    function automatic logic [3:0] ring_back(logic [3:0] i);
        return (i == 0) ? 4'(held_cap - 1) : i - 4'd1;
    endfunction

    function automatic logic [3:0] ring_fwd(logic [3:0] i);
        return (5'(i) + 5'd1 >= held_cap) ? 4'd0 : i + 4'd1;
    endfunction

    // applies one command to the shadow deque and returns the result it gives
    function automatic result_t apply_deque_op(cmd_t c);
        result_t r;
        logic    ok;
        logic    was_full;
        logic    was_empty;
        was_full  = occupancy >= held_cap;
        was_empty = occupancy == 0;
        ok        = 1'b0;
        case (c.action)
            ACT_QUERY:
            begin
                ok = 1'b1;
            end
            ACT_PUSH_FRONT:
            begin
                if (!was_full)
                begin
                    head_ptr       = ring_back(head_ptr);
                    ring[head_ptr] = c.value;
                    occupancy      = occupancy + 1'b1;
                    ok             = 1'b1;
                end
            end
            ACT_PUSH_REAR:
            begin
                if (!was_full)
                begin
                    ring[tail_ptr] = c.value;
                    tail_ptr       = ring_fwd(tail_ptr);
                    occupancy      = occupancy + 1'b1;
                    ok             = 1'b1;
                end
            end
            ACT_POP_FRONT:
            begin
                if (!was_empty)
                begin
                    head_ptr  = ring_fwd(head_ptr);
                    occupancy = occupancy - 1'b1;
                    ok        = 1'b1;
                end
            end
            ACT_POP_REAR:
            begin
                if (!was_empty)
                begin
                    tail_ptr  = ring_back(tail_ptr);
                    occupancy = occupancy - 1'b1;
                    ok        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.ok         = ok;
        r.empty_flag = occupancy == 0;
        r.full_flag  = occupancy >= held_cap;
        r.fill_count = occupancy;
        r.front_word = r.empty_flag ? EMPTY_WORD : ring[head_ptr];
        r.rear_word  = r.empty_flag ? EMPTY_WORD : ring[ring_back(tail_ptr)];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        logic    bad;
        if (!rst_n)
        begin
            held_cap      = clamp_capacity(CAP_W'(CAP_RESET_VALUE));
            head_ptr      = '0;
            tail_ptr      = '0;
            occupancy     = '0;
            fail_count    = 0;
            pending_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: result with nothing expected: ok=%0b count=%0d",
                                 $realtime, result.ok, result.fill_count);
                    end
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    bad = (result.ok !== exp_r.ok)
                       || (result.front_word !== exp_r.front_word)
                       || (result.rear_word !== exp_r.rear_word)
                       || (result.empty_flag !== exp_r.empty_flag)
                       || (result.full_flag !== exp_r.full_flag)
                       || (result.fill_count !== exp_r.fill_count);
                    if (bad)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch exp ok=%0b front=%0d rear=%0d e=%0b f=%0b n=%0d",
                                     $realtime, exp_r.ok, exp_r.front_word, exp_r.rear_word,
                                     exp_r.empty_flag, exp_r.full_flag, exp_r.fill_count);
                            $display("%0t:          got ok=%0b front=%0d rear=%0d e=%0b f=%0b n=%0d",
                                     $realtime, result.ok, result.front_word, result.rear_word,
                                     result.empty_flag, result.full_flag, result.fill_count);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                held_cap  = clamp_capacity(cfg_data);
                head_ptr  = '0;
                tail_ptr  = '0;
                occupancy = '0;
            end
            if (start && !busy)
            begin
                expected_results.push_back(apply_deque_op(cmd));
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// ===== verif/bounded_circular_deque_tb.sv =====
`timescale 1ns / 100ps

module bounded_circular_deque_tb;

    import bcd_pkg::*;

    localparam int RING_DEPTH = 16;
    // settle margin beyond the latency of one item
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS = 100;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    cmd_t                 cmd;
    logic                 busy;
    logic                 done;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data;
    int                   deque_errors;
    int                   results_owed;

    // capacities for the random phases: clamped low, extremes, clamped high, small, random
    logic [CAP_W-1:0] phase_caps [10];

    bounded_circular_deque
    #(
        .DEPTH(RING_DEPTH)
    )
    DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // watches all three channels, predicts and compares
    deque_checker
    #(
        .DEPTH(RING_DEPTH)
    )
    u_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .fail_count(deque_errors),
        .pending_count(results_owed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // word values lean on the signed extremes, zero and all ones
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // push_pct biases the mix toward filling or draining the deque
    function automatic cmd_t random_cmd(int push_pct);
        cmd_t c;
        int   r;
        r       = $urandom_range(0, 99);
        c.value = pick_word();
        if (r < 4)
        begin
            c.action = ACT_QUERY;
        end
        else if (r < 8)
        begin
            // undefined action codes: no change, ok low
            c.action = ACTION_W'($urandom_range(5, 7));
        end
        else if ($urandom_range(0, 99) < push_pct)
        begin
            c.action = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        end
        else
        begin
            c.action = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
        end
        return c;
    endfunction

    // drive one item at the falling edge and hold it until an edge takes it
    // start stays high on return so back-to-back items keep it asserted
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [WORD_W-1:0] val);
        logic taken;
        start     = 1'b1;
        cmd.action = act;
        cmd.value  = val;
        taken     = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
        @(negedge clk);
    endtask

    // sender gap, command bus carries noise while start is low
    task automatic hold_off(input int cycles);
        start = 1'b0;
        cmd   = random_cmd(50);
        repeat (cycles) @(negedge clk);
    endtask

    // stop sending until every owed result has come back
    task automatic drain_results();
        start = 1'b0;
        while (results_owed != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // capacity write, only with the deque idle
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        logic taken;
        drain_results();
        cfg_valid = 1'b1;
        cfg_data  = cap;
        taken     = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = cfg_ready;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
        repeat (2) @(negedge clk);
    endtask

    // bursts of random length, each with its own fill, drain or balanced bias
    task automatic random_phase(input int count, input bit pause_midway);
        int   sent;
        int   burst;
        int   bias;
        int   gap;
        cmd_t c;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
                0: bias = 80;
                1: bias = 20;
                default: bias = 50;
            endcase
            for (int k = 0; k < burst && sent < count; k++)
            begin
                c = random_cmd(bias);
                send_item(c.action, c.value);
                sent++;
            end
            if (pause_midway && sent >= count / 2)
            begin
                // full stop until the result side has caught up
                drain_results();
                pause_midway = 1'b0;
            end
            // about a quarter of bursts run straight into the next
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                hold_off(gap);
            end
        end
    endtask

    // run limit, far beyond the slowest correct run
    initial
    begin
        #(5_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        phase_caps = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd3,
                       5'd1, 5'd0, 5'd16};
        phase_caps[7] = CAP_W'($urandom_range(1, 16));
        phase_caps[8] = CAP_W'($urandom_range(0, 31));

        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // reset capacity: failed pops on empty, query, undefined codes
        send_item(ACT_POP_FRONT, 32'd0);
        send_item(ACT_POP_REAR, 32'd0);
        send_item(ACT_QUERY, '1);
        send_item(3'd5, '1);
        send_item(3'd6, 32'h5555_5555);
        send_item(3'd7, 32'haaaa_aaaa);
        // signed extremes at both ends
        send_item(ACT_PUSH_FRONT, 32'h7fff_ffff);
        send_item(ACT_PUSH_REAR, 32'h8000_0000);
        send_item(ACT_PUSH_FRONT, 32'd0);
        send_item(ACT_PUSH_REAR, '1);
        send_item(ACT_QUERY, 32'd0);
        send_item(ACT_POP_REAR, 32'd0);
        send_item(ACT_POP_FRONT, 32'd0);
        send_item(ACT_POP_FRONT, 32'd0);
        send_item(ACT_POP_REAR, 32'd0);
        send_item(ACT_POP_REAR, 32'd0);

        // single slot: full after one push, pushes then fail
        write_capacity(5'd1);
        send_item(ACT_PUSH_REAR, 32'h1234_5678);
        send_item(ACT_PUSH_FRONT, 32'hdead_beef);
        send_item(ACT_QUERY, 32'd0);
        send_item(ACT_POP_FRONT, 32'd0);
        send_item(ACT_POP_FRONT, 32'd0);
        send_item(ACT_PUSH_FRONT, 32'ha5a5_a5a5);
        send_item(ACT_POP_REAR, 32'd0);

        // random phases, each behind a capacity write
        for (int p = 0; p < 10; p++)
        begin
            write_capacity(phase_caps[p]);
            random_phase(PHASE_ITEMS, p == 3);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (deque_errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
